>>> hdl/cbsi_pkg.sv
// Shared types and constants for the cartridge bank and scanline IRQ block.
// Holds the item structs, the queue entry format and the decode codes.
// No dependencies.
package cbsi_pkg;

  // Configuration register indexes and reset values.
  localparam logic CFG_CHR_PAGES = 1'b0;
  localparam logic CFG_PRG_PAGES = 1'b1;
  localparam logic [10:0] CHR_PAGES_RESET = 11'd8;
  localparam logic [8:0]  PRG_PAGES_RESET = 9'd2;

  // Default depth of the queue between the front and back ends.
  localparam int CBSI_QUEUE_DEPTH = 2;

  // Input command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Write decode on address bits 15..11.
  localparam logic [4:0] DEC_CHR0   = 5'h11;
  localparam logic [4:0] DEC_CHR1   = 5'h13;
  localparam logic [4:0] DEC_CHR2   = 5'h15;
  localparam logic [4:0] DEC_CHR3   = 5'h17;
  localparam logic [4:0] DEC_LATCH  = 5'h19;
  localparam logic [4:0] DEC_ENABLE = 5'h1B;
  localparam logic [4:0] DEC_MIRROR = 5'h1D;
  localparam logic [4:0] DEC_PRG    = 5'h1F;

  // Scanline and counter constants.
  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [7:0] RELOAD_POINT      = 8'hF6;
  localparam int         ENABLE_BIT        = 4;

  // Result kinds.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CHR    = 2'd1;
  localparam logic [1:0] KIND_PRG    = 2'd2;
  localparam logic [1:0] KIND_MIRROR = 2'd3;

  // Operations handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CHR,
    OP_PRG,
    OP_MIRROR,
    OP_LATCH,
    OP_ENABLE,
    OP_TICK
  } cbsi_op_t;

  typedef struct packed {
    logic       cmd;
    logic [15:0] addr;
    logic [7:0] data;
    logic [8:0] scanline;
    logic       rendering_on;
  } cbsi_in_t;

  typedef struct packed {
    logic [1:0] update_kind;
    logic [1:0] chr_slot_pair;
    logic [7:0] page_first;
    logic [8:0] page_second;
    logic [1:0] mirroring_code;
    logic       irq_pulse;
  } cbsi_out_t;

  // One classified item: the operation, the slot pair and an operand byte.
  typedef struct packed {
    cbsi_op_t   op;
    logic [1:0] slot;
    logic [7:0] value;
  } cbsi_entry_t;

endpackage

>>> hdl/cbsi_front.sv
// Front end: accepts input items and classifies them into queue entries.
// Depends on cbsi_pkg.
module cbsi_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  cbsi_pkg::cbsi_in_t    in_item,
  input  logic              q_full,
  output logic              q_push,
  output cbsi_pkg::cbsi_entry_t q_entry
);
  import cbsi_pkg::*;

  logic [4:0] decode;
  logic [7:0] doubled;

  assign decode  = in_item.addr[15:11];
  assign doubled = {in_item.data[6:0], 1'b0};

  // An item is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the item; the tick qualifiers that do not need state are settled here.
  always_comb begin
    q_entry.op    = OP_NONE;
    q_entry.slot  = 2'd0;
    q_entry.value = 8'd0;
    if (in_item.cmd == CMD_TICK) begin
      if (in_item.scanline <= LAST_VISIBLE_LINE && in_item.rendering_on) begin
        q_entry.op = OP_TICK;
      end
    end else begin
      case (decode) inside
        DEC_CHR0, DEC_CHR1, DEC_CHR2, DEC_CHR3: begin
          q_entry.op    = OP_CHR;
          q_entry.slot  = in_item.addr[13:12];
          q_entry.value = doubled;
        end
        DEC_PRG: begin
          q_entry.op    = OP_PRG;
          q_entry.value = doubled;
        end
        DEC_MIRROR: begin
          q_entry.op    = OP_MIRROR;
          q_entry.value = {6'd0, in_item.data[1], ~in_item.data[0]};
        end
        DEC_LATCH: begin
          q_entry.op    = OP_LATCH;
          q_entry.value = in_item.data;
        end
        DEC_ENABLE: begin
          q_entry.op    = OP_ENABLE;
          q_entry.value = {7'd0, in_item.data[ENABLE_BIT]};
        end
        default: begin
          q_entry.op = OP_NONE;
        end
      endcase
    end
  end

endmodule

>>> hdl/cbsi_queue.sv
// Small first-in first-out queue of classified entries.
// Depends on cbsi_pkg for the entry type.
module cbsi_queue #(
  parameter int DEPTH = cbsi_pkg::CBSI_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cbsi_pkg::cbsi_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output cbsi_pkg::cbsi_entry_t pop_entry,
  output logic                  empty
);
  import cbsi_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cbsi_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/cbsi_back.sv
// Back end: executes queue entries, holds the IRQ state and the result register.
// Bank numbers are reduced by a bit-serial restoring remainder. Depends on cbsi_pkg.
module cbsi_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cbsi_pkg::cbsi_entry_t q_entry,
  output logic                  q_pop,
  input  logic [10:0]           chr_page_count,
  input  logic [8:0]            prg_page_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cbsi_pkg::cbsi_out_t   out_item
);
  import cbsi_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t      state;
  logic        irq_enabled;
  logic [7:0]  irq_counter;
  logic [7:0]  irq_reload;
  logic [10:0] divisor;
  logic [7:0]  dividend;
  logic [7:0]  rem;
  logic [2:0]  steps;
  logic [1:0]  div_kind;
  logic [1:0]  div_slot;

  logic        slot_free;
  logic [8:0]  trial;
  logic [10:0] trial_ext;
  logic [10:0] diff;
  logic [7:0]  rem_next;
  logic [7:0]  counter_dec;

  // Pop only when idle and the result register is free or being emptied.
  assign slot_free = !out_valid || out_ready;
  assign q_pop     = (state == ST_IDLE) && !q_empty && slot_free;

  // One remainder step: shift in the next dividend bit, subtract if it fits.
  // A zero divisor always subtracts nothing, leaving the dividend unchanged.
  assign trial     = {rem, dividend[7]};
  assign trial_ext = {2'b00, trial};
  assign diff      = trial_ext - divisor;
  assign rem_next  = (trial_ext >= divisor) ? diff[7:0] : trial[7:0];

  assign counter_dec = irq_counter - 8'd1;

  // State, IRQ registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      irq_enabled <= 1'b0;
      irq_counter <= 8'd0;
      irq_reload  <= 8'd0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            out_item <= '0;
            case (q_entry.op)
              OP_CHR, OP_PRG: begin
                divisor  <= (q_entry.op == OP_CHR) ? chr_page_count
                                                   : {2'b00, prg_page_count};
                div_kind <= (q_entry.op == OP_CHR) ? KIND_CHR : KIND_PRG;
                div_slot <= q_entry.slot;
                dividend <= q_entry.value;
                rem      <= 8'd0;
                steps    <= 3'd7;
                state    <= ST_DIV;
              end
              OP_MIRROR: begin
                out_item.update_kind    <= KIND_MIRROR;
                out_item.mirroring_code <= q_entry.value[1:0];
                out_valid               <= 1'b1;
              end
              OP_LATCH: begin
                irq_counter <= irq_reload;
                irq_reload  <= q_entry.value;
                out_valid   <= 1'b1;
              end
              OP_ENABLE: begin
                irq_enabled <= q_entry.value[0];
                out_valid   <= 1'b1;
              end
              OP_TICK: begin
                if (irq_enabled) begin
                  if (counter_dec == RELOAD_POINT) begin
                    irq_counter        <= irq_reload;
                    out_item.irq_pulse <= 1'b1;
                  end else begin
                    irq_counter <= counter_dec;
                  end
                end
                out_valid <= 1'b1;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_DIV: begin
          rem      <= rem_next;
          dividend <= {dividend[6:0], 1'b0};
          steps    <= steps - 3'd1;
          if (steps == 3'd0) begin
            out_item.update_kind    <= div_kind;
            out_item.chr_slot_pair  <= (div_kind == KIND_CHR) ? div_slot : 2'd0;
            out_item.page_first     <= rem_next;
            out_item.page_second    <= {1'b0, rem_next} + 9'd1;
            out_item.mirroring_code <= 2'd0;
            out_item.irq_pulse      <= 1'b0;
            out_valid               <= 1'b1;
            state                   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The result register stays empty while a remainder is in progress.
  a_div_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !out_valid)
    else $error("result valid during bank reduction");

  // A finished reduction is below a nonzero divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && steps == 3'd0 && divisor != 11'd0)
      |=> ({3'b000, out_item.page_first} < divisor))
    else $error("bank page not reduced below page count");

  // Bank results carry consecutive pages.
  a_page_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.update_kind == KIND_CHR || out_item.update_kind == KIND_PRG))
      |-> (out_item.page_second == {1'b0, out_item.page_first} + 9'd1))
    else $error("page pair not consecutive");

  // An IRQ pulse only comes with an empty update kind.
  a_pulse_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.irq_pulse) |-> (out_item.update_kind == KIND_NONE))
    else $error("IRQ pulse on a bank or mirroring result");

endmodule

>>> hdl/cartridge_bank_and_scanline_irq_top.sv
// Cartridge bank and scanline IRQ block. Each item passes the front end, the queue and
// the back end's result register; bank writes also run through the 8-step bit-serial
// remainder unit in the back end, which takes no new item until the remainder is done.
// Throughput: one non-bank item per cycle while out_ready does not stall the result.
// Synchronous reset clears the queue, the IRQ state and sets the page counts to 8 and 2.
module cartridge_bank_and_scanline_irq_top #(
  parameter int QUEUE_DEPTH = cbsi_pkg::CBSI_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cbsi_pkg::cbsi_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cbsi_pkg::cbsi_out_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data
);
  import cbsi_pkg::*;

  logic [10:0] chr_page_count;
  logic [8:0]  prg_page_count;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  cbsi_entry_t push_entry;
  cbsi_entry_t pop_entry;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      chr_page_count <= CHR_PAGES_RESET;
      prg_page_count <= PRG_PAGES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHR_PAGES: chr_page_count <= cfg_data;
        CFG_PRG_PAGES: prg_page_count <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  cbsi_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  cbsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  cbsi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .chr_page_count (chr_page_count),
    .prg_page_count (prg_page_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the cartridge bank and scanline IRQ block.
// Depends on cbsi_pkg and cartridge_bank_and_scanline_irq_top; it predicts every
// result in-line, then runs directed checks followed by random traffic under handshake stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbsi_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  cbsi_in_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  cbsi_out_t out_item;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_CHR_PAGES;
  logic [10:0] cfg_data = '0;

  // Predicted cartridge state: the page counts and the scanline counter.
  logic [10:0] chr_pages = CHR_PAGES_RESET;
  logic [8:0]  prg_pages = PRG_PAGES_RESET;
  logic        irq_armed = 1'b0;
  logic [7:0]  line_counter = '0;
  logic [7:0]  line_reload = '0;

  cbsi_out_t expected_results[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int irq_pulses_seen = 0;
  int settings_used = 0;

  logic [4:0] chr_codes [4] = '{DEC_CHR0, DEC_CHR1, DEC_CHR2, DEC_CHR3};
  int chr_settings [9] = '{2040, 1, 0, 255, 256, 3, 2047, 100, 8};
  int prg_settings [9] = '{510, 2, 0, 511, 1, 7, 255, 130, 2};

  cartridge_bank_and_scanline_irq_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Doubled byte reduced by the page count; a count of zero leaves it as is.
  function automatic logic [7:0] bank_page(input logic [7:0] data, input int unsigned count);
    int unsigned doubled;
    doubled = {data[6:0], 1'b0};
    if (count == 0) return 8'(doubled);
    return 8'(doubled % count);
  endfunction

  // Works out the result of one item and advances the predicted state.
  function automatic cbsi_out_t predict_bank_irq(input cbsi_in_t item);
    cbsi_out_t res;
    res = '0;
    if (item.cmd == CMD_TICK) begin
      if (irq_armed && item.scanline <= LAST_VISIBLE_LINE && item.rendering_on) begin
        line_counter = line_counter - 8'd1;
        if (line_counter == RELOAD_POINT) begin
          line_counter = line_reload;
          res.irq_pulse = 1'b1;
        end
      end
    end else begin
      case (item.addr[15:11])
        DEC_CHR0, DEC_CHR1, DEC_CHR2, DEC_CHR3: begin
          res.update_kind = KIND_CHR;
          res.chr_slot_pair = item.addr[13:12];
          res.page_first = bank_page(item.data, chr_pages);
          res.page_second = {1'b0, res.page_first} + 9'd1;
        end
        DEC_PRG: begin
          res.update_kind = KIND_PRG;
          res.page_first = bank_page(item.data, prg_pages);
          res.page_second = {1'b0, res.page_first} + 9'd1;
        end
        DEC_MIRROR: begin
          res.update_kind = KIND_MIRROR;
          res.mirroring_code = item.data[1:0] ^ 2'b01;
        end
        DEC_LATCH: begin
          line_counter = line_reload;
          line_reload = item.data;
        end
        DEC_ENABLE: begin
          irq_armed = item.data[ENABLE_BIT];
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  function automatic cbsi_in_t bus_write(input logic [15:0] addr, input logic [7:0] data);
    cbsi_in_t item;
    item = '0;
    item.cmd = CMD_WRITE;
    item.addr = addr;
    item.data = data;
    return item;
  endfunction

  function automatic cbsi_in_t scan_tick(input logic [8:0] line, input logic rend);
    cbsi_in_t item;
    item = '0;
    item.cmd = CMD_TICK;
    item.scanline = line;
    item.rendering_on = rend;
    return item;
  endfunction

  // Mostly well-formed traffic: visible-line ticks, decoded writes, reload values
  // near the reload point so the counter fires often, and a share of noise.
  function automatic cbsi_in_t random_traffic_item();
    cbsi_in_t item;
    int unsigned pick;
    item.addr = 16'($urandom);
    item.data = 8'($urandom);
    item.scanline = 9'($urandom);
    item.rendering_on = 1'($urandom);
    if ($urandom_range(99) < 40) begin
      item.cmd = CMD_TICK;
      if ($urandom_range(9) < 7) item.scanline = 9'($urandom_range(239));
      item.rendering_on = ($urandom_range(9) != 0);
    end else begin
      item.cmd = CMD_WRITE;
      pick = $urandom_range(19);
      if (pick < 6) begin
        item.addr[15:11] = chr_codes[$urandom_range(3)];
      end else if (pick < 8) begin
        item.addr[15:11] = DEC_PRG;
      end else if (pick < 10) begin
        item.addr[15:11] = DEC_MIRROR;
      end else if (pick < 13) begin
        item.addr[15:11] = DEC_LATCH;
        if ($urandom_range(1) == 1) item.data = 8'($urandom_range(8'hFF, 8'hF7));
      end else if (pick < 16) begin
        item.addr[15:11] = DEC_ENABLE;
        item.data[ENABLE_BIT] = ($urandom_range(4) != 0);
      end else begin
        // Any address outside the decoded windows.
        if (item.addr[15] && item.addr[11]) item.addr[11] = 1'b0;
      end
    end
    return item;
  endfunction

  // Sends one item, with a random gap before it, and records its prediction
  // at the edge where the transfer happens.
  task automatic send_item(input cbsi_in_t item);
    // Each cycle the sender stays idle with the current idle percentage.
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_bank_irq(item));
    items_sent++;
  endtask

  // Holds off the sender until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_page_counts(input logic [10:0] chr, input logic [8:0] prg);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHR_PAGES;
    cfg_data <= chr;
    @(posedge clk);
    cfg_index <= CFG_PRG_PAGES;
    cfg_data <= {2'b00, prg};
    @(posedge clk);
    cfg_we <= 1'b0;
    chr_pages = chr;
    prg_pages = prg;
    settings_used++;
  endtask

  function automatic void check_result(input cbsi_out_t want, input cbsi_out_t got);
    logic bad;
    bad = (got.update_kind !== want.update_kind) || (got.chr_slot_pair !== want.chr_slot_pair)
       || (got.page_first !== want.page_first) || (got.page_second !== want.page_second)
       || (got.mirroring_code !== want.mirroring_code) || (got.irq_pulse !== want.irq_pulse);
    results_checked++;
    if (want.irq_pulse) irq_pulses_seen++;
    if (bad) begin
      error_count++;
      if (error_count <= 10)
        $display("Mismatch on result %0d: kind %0d/%0d slot %0d/%0d first %0d/%0d",
                 results_checked, want.update_kind, got.update_kind, want.chr_slot_pair,
                 got.chr_slot_pair, want.page_first, got.page_first,
                 "  second %0d/%0d mirror %0d/%0d irq %0d/%0d (expected/actual)",
                 want.page_second, got.page_second, want.mirroring_code,
                 got.mirroring_code, want.irq_pulse, got.irq_pulse);
    end
  endfunction

  // Result side: check every transfer, then pick the next ready value.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("Result transfer with nothing expected: %h", out_item);
      end else begin
        check_result(expected_results.pop_front(), out_item);
      end
    end
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Bank pairs at the data extremes with reset page counts, then with counts of zero.
  task automatic test_bank_pages();
    send_item(bus_write(16'h8800, 8'hFF));
    send_item(bus_write(16'h9800, 8'hFF));
    send_item(bus_write(16'hA800, 8'h80));
    send_item(bus_write(16'hBFFF, 8'h00));
    send_item(bus_write(16'hFFFF, 8'hFF));
    send_item(bus_write(16'hF800, 8'h7F));
    wait_drained();
    set_page_counts(11'd0, 9'd0);
    send_item(bus_write(16'h8800, 8'hFF));
    send_item(bus_write(16'hF800, 8'h7F));
  endtask

  // Every mirroring code, plus writes that fall outside the decoded windows.
  task automatic test_mirroring_and_undecoded();
    send_item(bus_write(16'hE800, 8'h00));
    send_item(bus_write(16'hE800, 8'h01));
    send_item(bus_write(16'hEFFF, 8'h02));
    send_item(bus_write(16'hE800, 8'hFF));
    send_item(bus_write(16'h0000, 8'hFF));
    send_item(bus_write(16'h7800, 8'hAA));
    send_item(bus_write(16'hC000, 8'h55));
  endtask

  // Counter gating on enable, line and rendering, and the reload with a pulse.
  task automatic test_scanline_irq();
    send_item(scan_tick(9'd0, 1'b1));
    send_item(bus_write(16'hC800, 8'hF8));
    send_item(bus_write(16'hC800, 8'h03));
    send_item(bus_write(16'hD800, 8'h10));
    send_item(scan_tick(9'd0, 1'b1));
    send_item(scan_tick(9'd240, 1'b1));
    send_item(scan_tick(9'd511, 1'b1));
    send_item(scan_tick(9'd100, 1'b0));
    send_item(scan_tick(9'd239, 1'b1));
    send_item(bus_write(16'hD800, 8'hEF));
    send_item(scan_tick(9'd239, 1'b1));
  endtask

  // Random traffic in three idling profiles, each over several page-count settings.
  task automatic test_random_traffic();
    int tx_pct [3] = '{28, 82, 0};
    int rx_pct [3] = '{82, 28, 0};
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_pct[phase];
      rx_idle_pct = rx_pct[phase];
      for (int blk = 0; blk < 3; blk++) begin
        wait_drained();
        set_page_counts(11'(chr_settings[phase * 3 + blk]), 9'(prg_settings[phase * 3 + blk]));
        repeat (55) send_item(random_traffic_item());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 28;
    rx_idle_pct = 82;
    test_bank_pages();
    test_mirroring_and_undecoded();
    test_scanline_irq();
    test_random_traffic();
    wait_drained();
    $display("Sent %0d items and checked %0d results, %0d of them IRQ pulses,",
             items_sent, results_checked, irq_pulses_seen);
    $display("across %0d page-count settings and three stall profiles.", settings_used);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors, %0d results missing", error_count, expected_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
